// ===== rtl/core/rme_pkg.sv =====
// rme_pkg: shared constants, types and the cordic angle table for the
// rotation matrix to euler converter. No dependencies.
package rme_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int IN_W          = 16;
    localparam int THR_W         = 15;
    localparam int SQ_W          = 2 * FRAC_BITS + 2;
    localparam int ROOT_W        = FRAC_BITS + 1;
    localparam int SQRT_STEPS    = SQ_W / 2;
    localparam int CW            = 28;
    localparam int ZW            = 27;
    localparam int PITCH_LIM     = 11520;
    localparam int ANG_LIM       = 23040;
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

    // zf marks a zero vector, whose angle is forced to zero at the end
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zf;
    } cvec_t;

    // atan(2^-i) in degrees with 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = ZW'(2949120);
            5'd1:  r = ZW'(1740967);
            5'd2:  r = ZW'(919879);
            5'd3:  r = ZW'(466945);
            5'd4:  r = ZW'(234379);
            5'd5:  r = ZW'(117266);
            5'd6:  r = ZW'(58666);
            5'd7:  r = ZW'(29335);
            5'd8:  r = ZW'(14668);
            5'd9:  r = ZW'(7334);
            5'd10: r = ZW'(3667);
            5'd11: r = ZW'(1833);
            5'd12: r = ZW'(917);
            5'd13: r = ZW'(458);
            5'd14: r = ZW'(229);
            5'd15: r = ZW'(115);
            5'd16: r = ZW'(57);
            5'd17: r = ZW'(29);
            5'd18: r = ZW'(14);
            5'd19: r = ZW'(7);
            5'd20: r = ZW'(4);
            5'd21: r = ZW'(2);
            5'd22: r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // move operands to the right half plane and scale by the guard factor
    function automatic cvec_t cordic_pre(input logic signed [IN_W:0] y,
                                         input logic signed [IN_W:0] x);
        cvec_t r;
        logic signed [IN_W:0] xa;
        logic signed [IN_W:0] ya;
        xa = x;
        ya = y;
        r.z = '0;
        r.zf = (x == '0) && (y == '0);
        if (x < 0)
        begin
            r.z = (y >= 0) ? DEG180 : -DEG180;
            xa = -x;
            ya = -y;
        end
        r.x = CW'(xa) <<< 8;
        r.y = CW'(ya) <<< 8;
        return r;
    endfunction

    // round to 1/128 degree and saturate
    function automatic logic signed [IN_W-1:0] to_out(input logic signed [ZW-1:0] a,
                                                     input int lim);
        logic signed [ZW-1:0] r;
        r = (a + ZW'(256)) >>> 9;
        if (r > ZW'(lim))
            r = ZW'(lim);
        if (r < -ZW'(lim))
            r = -ZW'(lim);
        return IN_W'(r);
    endfunction

endpackage

// ===== rtl/core/rme_sqrt_cell.sv =====
// rme_sqrt_cell: one step of a restoring integer square root chain.
// Depends on rme_pkg.
module rme_sqrt_cell
    import rme_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   trial_bit,
    input  logic [SQ_W-1:0]   rem_in,
    input  logic [SQ_W-1:0]   root_in,
    output logic [SQ_W-1:0]   rem_out,
    output logic [SQ_W-1:0]   root_out
);
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_next;
    logic [SQ_W-1:0] root_next;
    logic [SQ_W-1:0] rem_reg;
    logic [SQ_W-1:0] root_reg;

    // compare and subtract one trial bit
    always_comb
    begin
        trial = root_in + trial_bit;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + trial_bit;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    // hold while the chain is frozen
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== rtl/core/rme_cordic_cell.sv =====
// rme_cordic_cell: one vectoring cordic micro-rotation, registered.
// Depends on rme_pkg.
module rme_cordic_cell
    import rme_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [4:0] k,
    input  cvec_t      v_in,
    output cvec_t      v_out
);
    cvec_t v_next;
    cvec_t v_reg;

    // rotate toward the x axis by atan(2^-k)
    always_comb
    begin
        v_next.zf = v_in.zf;
        if (v_in.y >= 0)
        begin
            v_next.x = v_in.x + (v_in.y >>> k);
            v_next.y = v_in.y - (v_in.x >>> k);
            v_next.z = v_in.z + atan_lut(k);
        end
        else
        begin
            v_next.x = v_in.x - (v_in.y >>> k);
            v_next.y = v_in.y + (v_in.x >>> k);
            v_next.z = v_in.z - atan_lut(k);
        end
    end

    // hold while the chain is frozen
    always_ff @(posedge clk)
    begin
        if (en)
            v_reg <= v_next;
    end

    assign v_out = v_reg;
endmodule

// ===== rtl/core/rotation_matrix_to_euler_top.sv =====
// rotation_matrix_to_euler_top: matrix to pitch/yaw/roll converter.
// Depends on rme_pkg, rme_sqrt_cell and rme_cordic_cell.
//
// usage
//   input channel: in_valid/in_ready with seven Q1.14 matrix elements
//   output channel: out_valid/out_ready with pitch, yaw, roll, gimbal_lock
//   cfg_we/cfg_data write lock_threshold (reset value 16)
// timing
//   a request enters a front register, a chain of 15 square root cells, an
//   entry register, then 16 cordic cells per angle (three angle chains in
//   parallel), then rounding and an output register.
//   one request is accepted every cycle while the output is taken.
// stalls
//   the whole chain advances together; when the receiver stalls with a
//   result waiting, the chain freezes and in_ready drops, so nothing is lost.
// reset
//   rst_n clears all valid bits and reloads lock_threshold; payload
//   registers are not reset.
module rotation_matrix_to_euler_top
    import rme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [THR_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [IN_W-1:0]   m00,
    input  logic signed [IN_W-1:0]   m01,
    input  logic signed [IN_W-1:0]   m02,
    input  logic signed [IN_W-1:0]   m10,
    input  logic signed [IN_W-1:0]   m11,
    input  logic signed [IN_W-1:0]   m12,
    input  logic signed [IN_W-1:0]   m22,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [IN_W-2:0]   pitch,
    output logic signed [IN_W-1:0]   yaw,
    output logic signed [IN_W-1:0]   roll,
    output logic                     gimbal_lock
);
    localparam int DEPTH = SQRT_STEPS + CORDIC_STAGES + 3;
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

    // whole chain is frozen by a stalled output
    logic adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;

    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(16);
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // front register: clamp sine and form 1 - s^2
    logic signed [IN_W-1:0] s_clamp;
    logic [SQ_W-1:0] sq_front_reg;
    logic signed [IN_W-1:0] s_reg [0:SQRT_STEPS];
    logic signed [IN_W-1:0] a_reg [0:SQRT_STEPS][0:5];
    logic [SQ_W-1:0] rem_w  [0:SQRT_STEPS];
    logic [SQ_W-1:0] root_w [0:SQRT_STEPS];

    always_comb
    begin
        s_clamp = m02;
        if (m02 > IN_W'(1 << FRAC_BITS))
            s_clamp = IN_W'(1 << FRAC_BITS);
        if (m02 < -IN_W'(1 << FRAC_BITS))
            s_clamp = -IN_W'(1 << FRAC_BITS);
    end

    // front register and side data delay alongside the square root chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_front_reg <= ONE_SQ - SQ_W'(s_clamp * s_clamp);
            s_reg[0]     <= s_clamp;
            a_reg[0][0]  <= m00;
            a_reg[0][1]  <= m01;
            a_reg[0][2]  <= m10;
            a_reg[0][3]  <= m11;
            a_reg[0][4]  <= m12;
            a_reg[0][5]  <= m22;
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                s_reg[i+1] <= s_reg[i];
                a_reg[i+1] <= a_reg[i];
            end
        end
    end

    assign rem_w[0]  = sq_front_reg;
    assign root_w[0] = '0;

    // square root chain, one trial bit per cell
    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] TRIAL_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
            rme_sqrt_cell u_sqrt (
                .clk(clk), .en(adv), .trial_bit(TRIAL_BIT),
                .rem_in(rem_w[g]), .root_in(root_w[g]),
                .rem_out(rem_w[g+1]), .root_out(root_w[g+1])
            );
        end
    endgenerate

    // cordic entry: three angle chains
    logic [ROOT_W-1:0] c_val;
    logic lock_now;
    cvec_t p0_reg;
    cvec_t q0_reg;
    cvec_t r0_reg;
    logic [CORDIC_STAGES:0] lk_reg;
    cvec_t p_w [0:CORDIC_STAGES];
    cvec_t q_w [0:CORDIC_STAGES];
    cvec_t r_w [0:CORDIC_STAGES];

    assign c_val    = ROOT_W'(root_w[SQRT_STEPS]);
    assign lock_now = !(c_val > ROOT_W'(thr_reg));

    // zero vector is flagged here; for yaw and roll its angle is cleared at the end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= cordic_pre(IN_W'(s_reg[SQRT_STEPS]), IN_W'(c_val));
            lk_reg <= {lk_reg[CORDIC_STAGES-1:0], lock_now};
            if (lock_now)
                q0_reg <= cordic_pre(IN_W'(a_reg[SQRT_STEPS][2]),
                                     IN_W'(a_reg[SQRT_STEPS][3]));
            else
                q0_reg <= cordic_pre(IN_W'(a_reg[SQRT_STEPS][1]),
                                     IN_W'(a_reg[SQRT_STEPS][0]));
            r0_reg <= cordic_pre(IN_W'(a_reg[SQRT_STEPS][4]),
                                 IN_W'(a_reg[SQRT_STEPS][5]));
        end
    end

    assign p_w[0] = p0_reg;
    assign q_w[0] = q0_reg;
    assign r_w[0] = r0_reg;

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cordic
            rme_cordic_cell u_p (.clk(clk), .en(adv), .k(5'(g)),
                                 .v_in(p_w[g]), .v_out(p_w[g+1]));
            rme_cordic_cell u_q (.clk(clk), .en(adv), .k(5'(g)),
                                 .v_in(q_w[g]), .v_out(q_w[g+1]));
            rme_cordic_cell u_r (.clk(clk), .en(adv), .k(5'(g)),
                                 .v_in(r_w[g]), .v_out(r_w[g+1]));
        end
    endgenerate

    // rounding and output register
    logic signed [ZW-1:0] q_z;
    logic signed [ZW-1:0] r_z;
    logic signed [IN_W-1:0] pitch_w;
    logic signed [IN_W-1:0] yaw_w;
    logic signed [IN_W-1:0] roll_w;
    logic signed [IN_W-2:0] pitch_reg;
    logic signed [IN_W-1:0] yaw_reg;
    logic signed [IN_W-1:0] roll_reg;
    logic lock_reg;

    assign q_z     = q_w[CORDIC_STAGES].zf ? '0 : q_w[CORDIC_STAGES].z;
    assign r_z     = r_w[CORDIC_STAGES].zf ? '0 : r_w[CORDIC_STAGES].z;
    assign pitch_w = to_out(-p_w[CORDIC_STAGES].z, PITCH_LIM);
    assign yaw_w   = lk_reg[CORDIC_STAGES] ? to_out(-q_z, ANG_LIM)
                                           : to_out(q_z, ANG_LIM);
    assign roll_w  = lk_reg[CORDIC_STAGES] ? '0 : to_out(r_z, ANG_LIM);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= (IN_W-1)'(pitch_w);
            yaw_reg   <= yaw_w;
            roll_reg  <= roll_w;
            lock_reg  <= lk_reg[CORDIC_STAGES];
        end
    end

    assign out_valid   = vld_reg[DEPTH-1];
    assign pitch       = pitch_reg;
    assign yaw         = yaw_reg;
    assign roll        = roll_reg;
    assign gimbal_lock = lock_reg;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(yaw) && $stable(pitch))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready does not follow chain advance");
    a_lock_roll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gimbal_lock |-> roll == 0)
        else $error("roll not zero under gimbal lock");
`endif
endmodule
